[hdl/sl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sl_pkg: shared definitions for the source lexer
// Token kind codes, counter widths and the keyword lookup.
// ----------------------------------------------------------------------------
package sl_pkg;

    localparam int OFFSET_BITS = 16;
    localparam int LINE_BITS   = 16;

    typedef logic [5:0]  t_kind;
    typedef logic [47:0] t_window;

    localparam t_kind K_EOF        = 6'd0;
    localparam t_kind K_IDENT      = 6'd1;
    localparam t_kind K_NUMBER     = 6'd2;
    localparam t_kind K_STRING     = 6'd3;
    localparam t_kind K_LPAREN     = 6'd4;
    localparam t_kind K_RPAREN     = 6'd5;
    localparam t_kind K_LBRACE     = 6'd6;
    localparam t_kind K_RBRACE     = 6'd7;
    localparam t_kind K_ARROW      = 6'd8;
    localparam t_kind K_MINUS      = 6'd9;
    localparam t_kind K_PLUS       = 6'd10;
    localparam t_kind K_STAR       = 6'd11;
    localparam t_kind K_SLASH      = 6'd12;
    localparam t_kind K_COMMA      = 6'd13;
    localparam t_kind K_SEMI       = 6'd14;
    localparam t_kind K_COLON      = 6'd15;
    localparam t_kind K_GE         = 6'd16;
    localparam t_kind K_GT         = 6'd17;
    localparam t_kind K_LE         = 6'd18;
    localparam t_kind K_LT         = 6'd19;
    localparam t_kind K_EQEQ       = 6'd20;
    localparam t_kind K_ASSIGN     = 6'd21;
    localparam t_kind K_QUEST      = 6'd22;
    localparam t_kind K_NE         = 6'd23;
    localparam t_kind K_KW_AND     = 6'd24;
    localparam t_kind K_KW_AUTO    = 6'd25;
    localparam t_kind K_KW_BOOL    = 6'd26;
    localparam t_kind K_KW_ELSE    = 6'd27;
    localparam t_kind K_KW_FALSE   = 6'd28;
    localparam t_kind K_KW_FLOAT   = 6'd29;
    localparam t_kind K_KW_FIXED   = 6'd30;
    localparam t_kind K_KW_FOR     = 6'd31;
    localparam t_kind K_KW_IF      = 6'd32;
    localparam t_kind K_KW_NOT     = 6'd33;
    localparam t_kind K_KW_NONE    = 6'd34;
    localparam t_kind K_KW_OR      = 6'd35;
    localparam t_kind K_KW_RETURN  = 6'd36;
    localparam t_kind K_KW_STR     = 6'd37;
    localparam t_kind K_KW_TRUE    = 6'd38;
    localparam t_kind K_KW_WHILE   = 6'd39;
    localparam t_kind K_ERR_CHAR   = 6'd40;
    localparam t_kind K_ERR_STRING = 6'd41;

    // Keyword windows hold the first byte of the word in the lowest byte,
    // with unused upper bytes zero.
    function automatic t_kind kw_lookup(input t_window win, input logic [2:0] len);
        t_kind k;
        k = K_IDENT;
        if      (len == 3'd3 && win == 48'h0000_0064_6E61) k = K_KW_AND;
        else if (len == 3'd4 && win == 48'h0000_6F74_7561) k = K_KW_AUTO;
        else if (len == 3'd4 && win == 48'h0000_6C6F_6F62) k = K_KW_BOOL;
        else if (len == 3'd4 && win == 48'h0000_6573_6C65) k = K_KW_ELSE;
        else if (len == 3'd5 && win == 48'h0065_736C_6166) k = K_KW_FALSE;
        else if (len == 3'd5 && win == 48'h0074_616F_6C66) k = K_KW_FLOAT;
        else if (len == 3'd5 && win == 48'h0064_6578_6966) k = K_KW_FIXED;
        else if (len == 3'd3 && win == 48'h0000_0072_6F66) k = K_KW_FOR;
        else if (len == 3'd2 && win == 48'h0000_0000_6669) k = K_KW_IF;
        else if (len == 3'd3 && win == 48'h0000_0074_6F6E) k = K_KW_NOT;
        else if (len == 3'd4 && win == 48'h0000_656E_6F6E) k = K_KW_NONE;
        else if (len == 3'd2 && win == 48'h0000_0000_726F) k = K_KW_OR;
        else if (len == 3'd6 && win == 48'h6E72_7574_6572) k = K_KW_RETURN;
        else if (len == 3'd3 && win == 48'h0000_0072_7473) k = K_KW_STR;
        else if (len == 3'd4 && win == 48'h0000_6575_7274) k = K_KW_TRUE;
        else if (len == 3'd5 && win == 48'h0065_6C69_6877) k = K_KW_WHILE;
        return k;
    endfunction

endpackage

[hdl/sl_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sl_in_if: source byte channel
// One word is a source byte or an end-of-source marker.
// ----------------------------------------------------------------------------
interface sl_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] char_byte;

    modport source (output valid, output kind, output char_byte, input ready);
    modport sink   (input valid, input kind, input char_byte, output ready);
endinterface

[hdl/sl_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sl_out_if: token channel
// One word is one token with its position, length and line.
// ----------------------------------------------------------------------------
interface sl_out_if;
    logic        valid;
    logic        ready;
    logic [5:0]  token_kind;
    logic [15:0] start_offset;
    logic [15:0] token_length;
    logic [15:0] line_number;
    logic        last_of_run;

    modport source (output valid, output token_kind, output start_offset,
                    output token_length, output line_number, output last_of_run,
                    input ready);
    modport sink   (input valid, input token_kind, input start_offset,
                    input token_length, input line_number, input last_of_run,
                    output ready);
endinterface

[hdl/source_lexer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// source_lexer: streaming lexical scanner
// Turns a byte stream into tokens with offset, length and line number.
// ----------------------------------------------------------------------------
// Channel   Dir  Payload                                          Handshake
// i_in      in   kind, char_byte                                  valid/ready
// o_out     out  token_kind, start_offset, token_length,          valid/ready
//                line_number, last_of_run
// i_cfg     in   i_cfg_data (first_line)                          i_cfg_we
//
// A byte enters the input register, is scanned there and its tokens
// (zero, one or two) go into a three-entry result queue. One byte per cycle
// is sustained while each byte yields at most one token and the sink keeps
// up; a byte that yields two tokens holds back the next byte. The queue
// room check (at most one entry held) sets the rate. Reset is synchronous,
// active low, and clears the scanner, the input register and the queue.
// ----------------------------------------------------------------------------
module source_lexer
    import sl_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    sl_in_if.sink         i_in,
    sl_out_if.source      o_out,
    input  logic          i_cfg_we,
    input  logic [15:0]   i_cfg_data
);

    typedef logic [OFFSET_BITS-1:0] t_off;
    typedef logic [LINE_BITS-1:0]   t_line;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] start;
        logic [15:0] length;
        logic [15:0] line;
        logic        last;
    } t_token;

    typedef enum logic [3:0] {
        M_IDLE, M_IDENT, M_NUM_INT, M_NUM_FRAC, M_STRING, M_COMMENT,
        M_MINUS, M_GT, M_LT, M_EQ, M_BANG
    } t_mode;

    localparam t_off  OFF_MAX  = '1;
    localparam t_line LINE_MAX = '1;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_QUEST  = 8'h3F;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    // Input register.
    logic       r_in_valid;
    logic       r_in_kind;
    logic [7:0] r_in_byte;

    // Scanner state.
    logic [15:0] r_first_line;
    t_mode       r_mode, n_mode;
    t_line       r_line, n_line;
    t_off        r_pos, n_pos;
    t_off        r_begin, n_begin;
    t_window     r_win, n_win;
    logic [2:0]  r_wl, n_wl;

    // Result queue.
    t_token      r_fifo [0:2];
    logic [1:0]  r_wr, r_rd;
    logic [1:0]  r_count;

    logic        proc_fire;
    logic        pop;
    logic [1:0]  n_push;
    t_token      e0, e1;

    function automatic logic [1:0] ptr_next(input logic [1:0] p);
        return (p == 2'd2) ? 2'd0 : p + 2'd1;
    endfunction

    function automatic t_token make_tok(input t_kind k, input t_off s, input t_off l,
                                        input t_line ln);
        t_token t;
        t.kind   = k;
        t.start  = 16'(s);
        t.length = 16'(l);
        t.line   = 16'(ln);
        t.last   = 1'b0;
        return t;
    endfunction

    assign proc_fire   = r_in_valid && (r_count <= 2'd1);
    assign pop         = o_out.valid && o_out.ready;
    assign i_in.ready  = !r_in_valid || proc_fire;

    // Scan of one word.
    logic   [7:0] c;
    logic         is_alpha, is_digit, consumed;
    t_off         diff, incl;
    t_line        line_restart;
    logic         fl_v, a_v, s_v;
    t_kind        fl_kind;
    t_off         fl_len;
    t_token       a_tok, s_tok;

    always_comb begin
        c        = r_in_byte;
        is_alpha = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == CH_UNDER;
        is_digit = c >= 8'h30 && c <= 8'h39;
        diff     = r_pos - r_begin;
        incl     = (diff == OFF_MAX) ? OFF_MAX : diff + t_off'(1);

        if (33'(r_first_line) > 33'(LINE_MAX)) begin
            line_restart = LINE_MAX;
        end else begin
            line_restart = LINE_BITS'(r_first_line);
        end

        // What the pending token becomes if it ends here.
        fl_v    = 1'b1;
        fl_len  = diff;
        fl_kind = K_IDENT;
        unique case (r_mode)
            M_IDENT:    fl_kind = kw_lookup(r_win, r_wl);
            M_NUM_INT,
            M_NUM_FRAC: fl_kind = K_NUMBER;
            M_MINUS:    fl_kind = K_MINUS;
            M_GT:       fl_kind = K_GT;
            M_LT:       fl_kind = K_LT;
            M_EQ:       fl_kind = K_ASSIGN;
            M_BANG: begin
                fl_kind = K_ERR_CHAR;
                fl_len  = t_off'(1);
            end
            M_STRING:   fl_kind = K_ERR_STRING;
            default:    fl_v = 1'b0;
        endcase

        n_mode   = r_mode;
        n_line   = r_line;
        n_pos    = r_pos;
        n_begin  = r_begin;
        n_win    = r_win;
        n_wl     = r_wl;
        consumed = 1'b0;
        a_v      = 1'b0;
        a_tok    = make_tok(fl_kind, r_begin, fl_len, r_line);
        s_v      = 1'b0;
        s_tok    = make_tok(K_EOF, r_pos, t_off'(0), r_line);

        if (r_in_kind) begin
            a_v     = fl_v;
            s_v     = 1'b1;
            n_mode  = M_IDLE;
            n_line  = line_restart;
            n_pos   = '0;
            n_begin = '0;
            n_win   = '0;
            n_wl    = '0;
        end else begin
            unique case (r_mode)
                M_IDENT: begin
                    if (is_alpha || is_digit) begin
                        consumed = 1'b1;
                        if (r_wl < 3'd6) n_win[8*r_wl +: 8] = c;
                        if (r_wl < 3'd7) n_wl = r_wl + 3'd1;
                    end
                end
                M_NUM_INT: begin
                    if (is_digit) begin
                        consumed = 1'b1;
                    end else if (c == CH_DOT) begin
                        consumed = 1'b1;
                        n_mode   = M_NUM_FRAC;
                    end
                end
                M_NUM_FRAC: consumed = is_digit;
                M_STRING: begin
                    consumed = 1'b1;
                    if (c == CH_QUOTE) begin
                        a_v    = 1'b1;
                        a_tok  = make_tok(K_STRING, r_begin, incl, r_line);
                        n_mode = M_IDLE;
                    end else if (c == CH_LF && r_line != LINE_MAX) begin
                        n_line = r_line + t_line'(1);
                    end
                end
                M_COMMENT: begin
                    consumed = 1'b1;
                    if (c == CH_LF) begin
                        n_mode = M_IDLE;
                        if (r_line != LINE_MAX) n_line = r_line + t_line'(1);
                    end
                end
                M_MINUS: begin
                    if (c == CH_GT) begin
                        consumed = 1'b1;
                        a_v      = 1'b1;
                        a_tok    = make_tok(K_ARROW, r_begin, incl, r_line);
                        n_mode   = M_IDLE;
                    end
                end
                M_GT, M_LT, M_EQ, M_BANG: begin
                    if (c == CH_EQ) begin
                        consumed = 1'b1;
                        a_v      = 1'b1;
                        n_mode   = M_IDLE;
                        unique case (r_mode)
                            M_GT:    a_tok = make_tok(K_GE, r_begin, incl, r_line);
                            M_LT:    a_tok = make_tok(K_LE, r_begin, incl, r_line);
                            M_EQ:    a_tok = make_tok(K_EQEQ, r_begin, incl, r_line);
                            default: a_tok = make_tok(K_NE, r_begin, incl, r_line);
                        endcase
                    end
                end
                default: consumed = 1'b0;
            endcase

            if (!consumed) begin
                // The pending token ends before this byte, which then starts anew.
                a_v    = fl_v;
                n_mode = M_IDLE;
                s_tok  = make_tok(K_ERR_CHAR, r_pos, t_off'(1), r_line);
                unique case (c)
                    CH_SPACE, CH_CR, CH_TAB: s_v = 1'b0;
                    CH_LF:     if (r_line != LINE_MAX) n_line = r_line + t_line'(1);
                    CH_HASH:   n_mode = M_COMMENT;
                    CH_LPAREN: begin s_v = 1'b1; s_tok.kind = K_LPAREN; end
                    CH_RPAREN: begin s_v = 1'b1; s_tok.kind = K_RPAREN; end
                    CH_LBRACE: begin s_v = 1'b1; s_tok.kind = K_LBRACE; end
                    CH_RBRACE: begin s_v = 1'b1; s_tok.kind = K_RBRACE; end
                    CH_PLUS:   begin s_v = 1'b1; s_tok.kind = K_PLUS;   end
                    CH_STAR:   begin s_v = 1'b1; s_tok.kind = K_STAR;   end
                    CH_SLASH:  begin s_v = 1'b1; s_tok.kind = K_SLASH;  end
                    CH_COMMA:  begin s_v = 1'b1; s_tok.kind = K_COMMA;  end
                    CH_SEMI:   begin s_v = 1'b1; s_tok.kind = K_SEMI;   end
                    CH_COLON:  begin s_v = 1'b1; s_tok.kind = K_COLON;  end
                    CH_QUEST:  begin s_v = 1'b1; s_tok.kind = K_QUEST;  end
                    CH_MINUS:  begin n_mode = M_MINUS;  n_begin = r_pos; end
                    CH_GT:     begin n_mode = M_GT;     n_begin = r_pos; end
                    CH_LT:     begin n_mode = M_LT;     n_begin = r_pos; end
                    CH_EQ:     begin n_mode = M_EQ;     n_begin = r_pos; end
                    CH_BANG:   begin n_mode = M_BANG;   n_begin = r_pos; end
                    CH_QUOTE:  begin n_mode = M_STRING; n_begin = r_pos; end
                    default: begin
                        if (is_alpha) begin
                            n_mode  = M_IDENT;
                            n_begin = r_pos;
                            n_win   = t_window'(c);
                            n_wl    = 3'd1;
                        end else if (is_digit) begin
                            n_mode  = M_NUM_INT;
                            n_begin = r_pos;
                        end else begin
                            s_v = 1'b1;
                        end
                    end
                endcase
            end

            if (r_pos != OFF_MAX) n_pos = r_pos + t_off'(1);
        end

        // Pack the results in order and mark the final one.
        e0     = a_v ? a_tok : s_tok;
        e1     = s_tok;
        n_push = 2'(a_v) + 2'(s_v);
        e0.last = (n_push == 2'd1);
        e1.last = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_first_line <= 16'd1;
            r_mode       <= M_IDLE;
            r_line       <= t_line'(1);
            r_pos        <= '0;
            r_begin      <= '0;
            r_win        <= '0;
            r_wl         <= '0;
            r_wr         <= '0;
            r_rd         <= '0;
            r_count      <= '0;
        end else begin
            if (i_cfg_we) r_first_line <= i_cfg_data;

            if (i_in.valid && i_in.ready) begin
                r_in_valid <= 1'b1;
                r_in_kind  <= i_in.kind;
                r_in_byte  <= i_in.char_byte;
            end else if (proc_fire) begin
                r_in_valid <= 1'b0;
            end

            if (proc_fire) begin
                r_mode  <= n_mode;
                r_line  <= n_line;
                r_pos   <= n_pos;
                r_begin <= n_begin;
                r_win   <= n_win;
                r_wl    <= n_wl;
                if (n_push != 2'd0) r_fifo[r_wr] <= e0;
                if (n_push == 2'd2) r_fifo[ptr_next(r_wr)] <= e1;
                if (n_push == 2'd1) r_wr <= ptr_next(r_wr);
                if (n_push == 2'd2) r_wr <= ptr_next(ptr_next(r_wr));
            end

            if (pop) r_rd <= ptr_next(r_rd);
            r_count <= r_count + (proc_fire ? n_push : 2'd0) - 2'(pop);
        end
    end

    assign o_out.valid        = (r_count != 2'd0);
    assign o_out.token_kind   = r_fifo[r_rd].kind;
    assign o_out.start_offset = r_fifo[r_rd].start;
    assign o_out.token_length = r_fifo[r_rd].length;
    assign o_out.line_number  = r_fifo[r_rd].line;
    assign o_out.last_of_run  = r_fifo[r_rd].last;

    // An end marker always yields at least the Eof word.
    a_eof_pushes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc_fire && r_in_kind) |-> (n_push != 2'd0))
        else $error("end marker produced no token");

    // After an end marker the scanner is back at the start of a source.
    a_eof_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc_fire && r_in_kind) |=> (r_pos == '0 && r_mode == M_IDLE && r_wl == 3'd0))
        else $error("scanner not restarted after end marker");

    // The byte counter never moves backward within a source.
    a_pos_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc_fire && !r_in_kind) |=> (r_pos >= $past(r_pos)))
        else $error("byte position went backward");

    // The queue never overflows its three entries.
    a_queue_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc_fire |-> (3'(r_count) + 3'(n_push) <= 3'd3))
        else $error("result queue overflow");

endmodule

[bench/source_lexer_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// source_lexer_tb: self-checking bench for the streaming source lexer
// A directed run over error bytes, lookahead operators, strings and end
// markers is followed by random sources built from keywords, identifiers,
// numbers, strings, comments and noise. Every accepted byte goes through a
// scanner model in the bench, and every token word is compared field by field
// with the oldest predicted token. The line counter is also driven into
// saturation, and the base line register is set to zero, to its top values and to a random one.
// ----------------------------------------------------------------------------
module source_lexer_tb
    import sl_pkg::*;
();

    localparam int unsigned OFF_MAX     = (1 << OFFSET_BITS) - 1;
    localparam int unsigned LINE_MAX    = (1 << LINE_BITS) - 1;
    localparam int          SETTLE      = 8;
    localparam int          HOLD_LEN    = 300;
    localparam int          QUIET_LIMIT = 3000;
    localparam int          N_DIR       = 25;
    localparam logic [7:0]  CH_CR       = 8'h0D;

    localparam string ALPHA    = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
    localparam string DIGITS   = "0123456789";
    localparam string PUNCT    = "(){}+*/,;:?";
    localparam string STR_POOL = "ab Z#(9!=-\n\t";

    typedef enum logic [3:0] {
        SC_IDLE, SC_WORD, SC_INT, SC_FRAC, SC_STR, SC_NOTE,
        SC_MINUS, SC_GT, SC_LT, SC_EQ, SC_BANG
    } t_scan_mode;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] offset;
        logic [15:0] length;
        logic [15:0] line_no;
        logic        last;
    } t_exp_token;

    typedef struct packed {
        logic       eom;
        logic [7:0] ch;
        logic       typed;
        t_exp_token tok;
    } t_dir_row;

    localparam t_exp_token NO_TOK = '0;

    // Rows with a typed token cause exactly that one token; the rest are
    // checked against the scanner model.
    t_dir_row dir_rows [N_DIR] = '{
        '{1'b0, 8'h00, 1'b1, '{K_ERR_CHAR, 16'd0, 16'd1, 16'd1, 1'b1}},
        '{1'b0, 8'hFF, 1'b1, '{K_ERR_CHAR, 16'd1, 16'd1, 16'd1, 1'b1}},
        '{1'b0, 8'h80, 1'b1, '{K_ERR_CHAR, 16'd2, 16'd1, 16'd1, 1'b1}},
        '{1'b0, "!",   1'b0, NO_TOK},
        '{1'b0, "a",   1'b1, '{K_ERR_CHAR, 16'd3, 16'd1, 16'd1, 1'b1}},
        '{1'b0, "=",   1'b0, NO_TOK},
        '{1'b0, "=",   1'b0, NO_TOK},
        '{1'b0, "\n",  1'b0, NO_TOK},
        '{1'b0, "\"",  1'b0, NO_TOK},
        '{1'b0, "\n",  1'b0, NO_TOK},
        '{1'b0, "\"",  1'b0, NO_TOK},
        '{1'b0, "1",   1'b0, NO_TOK},
        '{1'b0, ".",   1'b0, NO_TOK},
        '{1'b0, "5",   1'b0, NO_TOK},
        '{1'b0, "-",   1'b0, NO_TOK},
        '{1'b0, ">",   1'b0, NO_TOK},
        '{1'b0, "#",   1'b0, NO_TOK},
        '{1'b0, "x",   1'b0, NO_TOK},
        '{1'b0, "\n",  1'b0, NO_TOK},
        '{1'b0, "i",   1'b0, NO_TOK},
        '{1'b0, "f",   1'b0, NO_TOK},
        '{1'b0, "\"",  1'b0, NO_TOK},
        '{1'b0, "x",   1'b0, NO_TOK},
        '{1'b1, 8'hFF, 1'b0, NO_TOK},
        '{1'b1, 8'h00, 1'b1, '{K_EOF, 16'd0, 16'd0, 16'd1, 1'b1}}
    };

    string kw_text [16] = '{"and", "auto", "bool", "else", "false", "float", "fixed",
                            "for", "if", "not", "none", "or", "return", "str", "true",
                            "while"};
    string op_text [10] = '{"->", ">=", "<=", "==", "!=", "-", ">", "<", "=", "!"};

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [15:0] cfg_data;
    logic        typed_on;
    t_exp_token  typed_tok;
    logic        gaps_on;
    logic        hold_req;
    logic        hold_done;

    sl_in_if  in_if ();
    sl_out_if out_if ();

    source_lexer dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Scanner model
    // ------------------------------------------------------------------
    logic [15:0] base_line;
    t_scan_mode  mode;
    int unsigned line_cnt;
    int unsigned pos;
    int unsigned tok_begin;
    logic [47:0] word_bits;     // first six bytes of the word, newest lowest
    int          word_len;      // saturates at 7

    t_exp_token  token_q [$];

    int n_mismatch = 0;
    int n_checked  = 0;
    int n_keyword  = 0;
    int n_errtok   = 0;
    int bytes_sent = 0;
    int ends_sent  = 0;
    logic [15:0] mid_base;

    function automatic bit is_alpha(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic void restart_source();
        mode      = SC_IDLE;
        line_cnt  = (base_line > LINE_MAX) ? LINE_MAX : base_line;
        pos       = 0;
        tok_begin = 0;
        word_bits = '0;
        word_len  = 0;
    endfunction

    function automatic void bump_line();
        if (line_cnt < LINE_MAX) line_cnt++;
    endfunction

    function automatic void put_token(t_kind k, int unsigned s, int unsigned n);
        t_exp_token t;
        if (n > OFF_MAX) n = OFF_MAX;
        t.kind    = k;
        t.offset  = 16'(s);
        t.length  = 16'(n);
        t.line_no = 16'(line_cnt);
        t.last    = 1'b0;
        token_q   = {token_q, t};
    endfunction

    // Words longer than six bytes can never be keywords; shorter ones are
    // told apart by their bytes alone since no identifier byte is zero.
    function automatic t_kind word_kind();
        if (word_len > 6) return K_IDENT;
        case (word_bits)
            "and":    return K_KW_AND;
            "auto":   return K_KW_AUTO;
            "bool":   return K_KW_BOOL;
            "else":   return K_KW_ELSE;
            "false":  return K_KW_FALSE;
            "float":  return K_KW_FLOAT;
            "fixed":  return K_KW_FIXED;
            "for":    return K_KW_FOR;
            "if":     return K_KW_IF;
            "not":    return K_KW_NOT;
            "none":   return K_KW_NONE;
            "or":     return K_KW_OR;
            "return": return K_KW_RETURN;
            "str":    return K_KW_STR;
            "true":   return K_KW_TRUE;
            "while":  return K_KW_WHILE;
            default:  return K_IDENT;
        endcase
    endfunction

    function automatic void close_pending();
        int unsigned n;
        n = pos - tok_begin;
        case (mode)
            SC_WORD:         put_token(word_kind(), tok_begin, n);
            SC_INT, SC_FRAC: put_token(K_NUMBER, tok_begin, n);
            SC_MINUS:        put_token(K_MINUS, tok_begin, n);
            SC_GT:           put_token(K_GT, tok_begin, n);
            SC_LT:           put_token(K_LT, tok_begin, n);
            SC_EQ:           put_token(K_ASSIGN, tok_begin, n);
            SC_BANG:         put_token(K_ERR_CHAR, tok_begin, 1);
            SC_STR:          put_token(K_ERR_STRING, tok_begin, n);
            default: ;
        endcase
        mode = SC_IDLE;
    endfunction

    // True when the byte belongs to the token already in progress.
    function automatic bit extend_pending(logic [7:0] c);
        int unsigned span;
        span = pos - tok_begin + 1;
        case (mode)
            SC_WORD: begin
                if (!(is_alpha(c) || is_digit(c))) return 1'b0;
                if (word_len < 6) word_bits = {word_bits[39:0], c};
                if (word_len < 7) word_len++;
                return 1'b1;
            end
            SC_INT: begin
                if (is_digit(c)) return 1'b1;
                if (c == ".") begin
                    mode = SC_FRAC;
                    return 1'b1;
                end
                return 1'b0;
            end
            SC_FRAC: return is_digit(c);
            SC_STR: begin
                if (c == "\"") begin
                    put_token(K_STRING, tok_begin, span);
                    mode = SC_IDLE;
                end else if (c == "\n") begin
                    bump_line();
                end
                return 1'b1;
            end
            SC_NOTE: begin
                if (c == "\n") begin
                    bump_line();
                    mode = SC_IDLE;
                end
                return 1'b1;
            end
            SC_MINUS: begin
                if (c != ">") return 1'b0;
                put_token(K_ARROW, tok_begin, span);
                mode = SC_IDLE;
                return 1'b1;
            end
            SC_GT, SC_LT, SC_EQ, SC_BANG: begin
                if (c != "=") return 1'b0;
                case (mode)
                    SC_GT:   put_token(K_GE, tok_begin, span);
                    SC_LT:   put_token(K_LE, tok_begin, span);
                    SC_EQ:   put_token(K_EQEQ, tok_begin, span);
                    default: put_token(K_NE, tok_begin, span);
                endcase
                mode = SC_IDLE;
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    function automatic void begin_token(logic [7:0] c);
        t_scan_mode next_mode;
        next_mode = SC_IDLE;
        case (c)
            " ", "\t", CH_CR: return;
            "\n": begin
                bump_line();
                return;
            end
            "#": begin
                mode = SC_NOTE;
                return;
            end
            "(": begin put_token(K_LPAREN, pos, 1); return; end
            ")": begin put_token(K_RPAREN, pos, 1); return; end
            "{": begin put_token(K_LBRACE, pos, 1); return; end
            "}": begin put_token(K_RBRACE, pos, 1); return; end
            "+": begin put_token(K_PLUS, pos, 1); return; end
            "*": begin put_token(K_STAR, pos, 1); return; end
            "/": begin put_token(K_SLASH, pos, 1); return; end
            ",": begin put_token(K_COMMA, pos, 1); return; end
            ";": begin put_token(K_SEMI, pos, 1); return; end
            ":": begin put_token(K_COLON, pos, 1); return; end
            "?": begin put_token(K_QUEST, pos, 1); return; end
            "-":  next_mode = SC_MINUS;
            ">":  next_mode = SC_GT;
            "<":  next_mode = SC_LT;
            "=":  next_mode = SC_EQ;
            "!":  next_mode = SC_BANG;
            "\"": next_mode = SC_STR;
            default: begin
                if (is_alpha(c)) begin
                    next_mode = SC_WORD;
                    word_bits = {40'd0, c};
                    word_len  = 1;
                end else if (is_digit(c)) begin
                    next_mode = SC_INT;
                end else begin
                    put_token(K_ERR_CHAR, pos, 1);
                    return;
                end
            end
        endcase
        mode      = next_mode;
        tok_begin = pos;
    endfunction

    function automatic void scan_word(logic eom, logic [7:0] c);
        int n0;
        n0 = token_q.size();
        if (eom) begin
            close_pending();
            put_token(K_EOF, pos, 0);
            restart_source();
        end else begin
            if (!extend_pending(c)) begin
                close_pending();
                begin_token(c);
            end
            if (pos < OFF_MAX) pos++;
        end
        if (token_q.size() > n0) token_q[token_q.size() - 1].last = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic note_mismatch(input string msg);
        n_mismatch++;
        $display("tb: mismatch: %s", msg);
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            note_mismatch($sformatf("token %0d %s: got %0d, expected %0d",
                                    n_checked, name, got, want));
    endtask

    always @(posedge clk) begin
        t_exp_token got;
        t_exp_token want;
        int         n0;
        if (!rst_n) begin
            base_line = 16'd1;
            restart_source();
            token_q.delete();
        end else begin
            if (cfg_we) base_line = cfg_data;
            if (in_if.valid && in_if.ready) begin
                n0 = token_q.size();
                scan_word(in_if.kind, in_if.char_byte);
                if (typed_on) begin
                    if (token_q.size() != n0 + 1) begin
                        note_mismatch("directed row does not yield exactly one token");
                    end else begin
                        token_q[token_q.size() - 1] = typed_tok;
                    end
                end
            end
            if ($isunknown(out_if.valid)) begin
                note_mismatch("token valid is unknown");
            end else if (out_if.valid && out_if.ready) begin
                got = '{out_if.token_kind, out_if.start_offset, out_if.token_length,
                        out_if.line_number, out_if.last_of_run};
                if (token_q.size() == 0) begin
                    note_mismatch($sformatf("token %0d arrived with none expected (kind %0d)",
                                            n_checked, got.kind));
                end else begin
                    want = token_q.pop_front();
                    check_field("kind", 16'(got.kind), 16'(want.kind));
                    check_field("offset", got.offset, want.offset);
                    check_field("length", got.length, want.length);
                    check_field("line", got.line_no, want.line_no);
                    check_field("last", 16'(got.last), 16'(want.last));
                    if (want.kind >= K_KW_AND && want.kind <= K_KW_WHILE) n_keyword++;
                    if (want.kind >= K_ERR_CHAR) n_errtok++;
                end
                n_checked++;
            end
        end
    end

    // Ends the run when neither channel moves for too long.
    int quiet_cycles = 0;
    always @(posedge clk) begin
        if (!rst_n || cfg_we || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb: no word moved for %0d cycles", QUIET_LIMIT);
            $display("tb: failure");
            $finish;
        end
    end

    // Token side: random stalls, or one long hold-off when asked for.
    initial begin
        out_if.ready = 1'b0;
        hold_done    = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req && !hold_done) begin
                out_if.ready <= 1'b0;
                repeat (HOLD_LEN) @(posedge clk);
                hold_done = 1'b1;
            end else begin
                out_if.ready <= !(gaps_on && $urandom_range(99) < 32);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    logic [7:0] text_q [$];

    function automatic void add_byte(logic [7:0] b);
        text_q = {text_q, b};
    endfunction

    task automatic push_word(input logic eom, input logic [7:0] c, input logic typed,
                             input t_exp_token tok);
        while (gaps_on && $urandom_range(99) < 32) begin
            in_if.valid <= 1'b0;
            @(posedge clk);
        end
        in_if.valid     <= 1'b1;
        in_if.kind      <= eom;
        in_if.char_byte <= c;
        typed_on        <= typed;
        typed_tok       <= tok;
        do @(posedge clk); while (in_if.ready !== 1'b1);
        if (eom) ends_sent++;
        else bytes_sent++;
    endtask

    task automatic send_byte(input logic [7:0] c);
        push_word(1'b0, c, 1'b0, NO_TOK);
    endtask

    // The byte that goes with an end marker is ignored, so it is random.
    task automatic send_end();
        push_word(1'b1, 8'($urandom_range(255)), 1'b0, NO_TOK);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    task automatic wait_drained();
        in_if.valid <= 1'b0;
        do @(posedge clk); while (token_q.size() != 0);
    endtask

    // The new base line applies from the next end marker on, so one follows.
    task automatic write_first_line(input logic [15:0] v);
        wait_drained();
        repeat (SETTLE) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we   <= 1'b0;
        send_end();
    endtask

    function automatic logic [7:0] pick(string pool);
        return pool[$urandom_range(pool.len() - 1)];
    endfunction

    function automatic logic [7:0] any_but(logic [7:0] avoid, logic [7:0] alt);
        logic [7:0] c;
        c = 8'($urandom_range(255));
        return (c == avoid) ? alt : c;
    endfunction

    function automatic void add_lexeme();
        int    sel;
        int    n;
        int    v;
        string w;
        sel = $urandom_range(99);
        if (sel < 16) begin
            // Keywords, with prefixes and extensions that must stay identifiers.
            w = kw_text[$urandom_range(15)];
            n = w.len();
            v = $urandom_range(4);
            if (v == 3) n--;
            for (int i = 0; i < n; i++) add_byte(w[i]);
            if (v == 4) repeat ($urandom_range(1, 3)) add_byte(pick(ALPHA));
        end else if (sel < 30) begin
            add_byte(pick(ALPHA));
            repeat ($urandom_range(0, ($urandom_range(99) < 10) ? 8 : 3))
                add_byte($urandom_range(1) ? pick(ALPHA) : pick(DIGITS));
        end else if (sel < 42) begin
            repeat ($urandom_range(1, 4)) add_byte(pick(DIGITS));
            if ($urandom_range(99) < 40) begin
                add_byte(".");
                repeat ($urandom_range(0, 3)) add_byte(pick(DIGITS));
            end
        end else if (sel < 50) begin
            add_byte("\"");
            repeat ($urandom_range(0, 6))
                add_byte(($urandom_range(99) < 70) ? pick(STR_POOL) : any_but("\"", "q"));
            add_byte("\"");
        end else if (sel < 62) begin
            add_byte(pick(PUNCT));
        end else if (sel < 75) begin
            w = op_text[$urandom_range(9)];
            for (int i = 0; i < w.len(); i++) add_byte(w[i]);
        end else if (sel < 82) begin
            add_byte("#");
            repeat ($urandom_range(0, 8)) add_byte(any_but("\n", " "));
            add_byte("\n");
        end else if (sel < 90) begin
            add_byte(8'($urandom_range(255)));
        end else begin
            add_byte(pick(" \t\n"));
            add_byte(CH_CR);
        end
    endfunction

    // Half the time tokens abut, which exercises the one-byte lookahead.
    function automatic void add_gap();
        case ($urandom_range(7))
            4: add_byte(" ");
            5: add_byte("\t");
            6: add_byte("\n");
            7: add_byte(CH_CR);
            default: ;
        endcase
    endfunction

    task automatic send_source(input int n_lex);
        text_q.delete();
        repeat (n_lex) begin
            add_lexeme();
            add_gap();
        end
        // Sometimes leave a string open at the end of the source.
        if ($urandom_range(99) < 15) begin
            add_byte("\"");
            repeat ($urandom_range(0, 4)) add_byte(pick(STR_POOL));
        end
        foreach (text_q[i]) send_byte(text_q[i]);
        send_end();
    endtask

    task automatic run_random(input int budget);
        int start;
        start = bytes_sent + ends_sent;
        while (bytes_sent + ends_sent - start < budget)
            send_source(($urandom_range(99) < 5) ? 0 : $urandom_range(2, 12));
    endtask

    initial begin
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_data        = 16'd0;
        in_if.valid     = 1'b0;
        in_if.kind      = 1'b0;
        in_if.char_byte = 8'd0;
        typed_on        = 1'b0;
        typed_tok       = NO_TOK;
        gaps_on         = 1'b1;
        hold_req        = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < N_DIR; i++)
            push_word(dir_rows[i].eom, dir_rows[i].ch, dir_rows[i].typed, dir_rows[i].tok);

        write_first_line(16'd0);
        run_random(250);

        // Newlines push the line counter into saturation.
        write_first_line(16'hFFFE);
        send_text("\n\n\nz \n");
        send_end();
        run_random(100);

        mid_base = 16'($urandom_range(65535));
        write_first_line(mid_base);
        gaps_on = 1'b0;
        run_random(120);
        hold_req = 1'b1;
        send_source(20);
        wait_drained();
        gaps_on = 1'b1;
        run_random(130);

        // A short source under the largest base line.
        write_first_line(16'hFFFF);
        send_text(" (\na");
        send_end();
        send_source(8);

        wait_drained();
        repeat (SETTLE) @(posedge clk);
        $display("tb: %0d bytes over %0d end markers, %0d tokens checked",
                 bytes_sent, ends_sent, n_checked);
        $display("tb: %0d keywords, %0d error tokens, base lines 1 0 65534 %0d 65535",
                 n_keyword, n_errtok, mid_base);
        if (n_mismatch == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: %0d mismatches", n_mismatch);
            $display("tb: failure");
        end
        $finish;
    end

endmodule
